// File: src/bjtem_pkg.sv
// Shared constants, types and helpers for the Ebers-Moll current unit.
package bjtem_pkg;

    localparam int VOLT_W  = 24;   // Q4.20 junction voltage
    localparam int RECIP_W = 24;   // unsigned Q8.16 reciprocals
    localparam int LOGIS_W = 25;   // signed Q9.16 log of saturation current
    localparam int X_W     = 30;   // exponent argument, Q.16
    localparam int E_W     = 57;   // exponential / product magnitude, Q.32
    localparam int SUM_W   = 60;   // signed sum of four magnitudes
    localparam int OUT_W   = 48;   // signed Q16.32 result

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [30:0] ONE_Q30   = 31'd1073741824;
    // ceil(2^29/3): exact floor(y/3) for y below 2^27
    localparam logic [27:0] RECIP3_Q29 = 28'd178956971;
    localparam logic [E_W-1:0] CAP_VAL = E_W'(1) << 56;

    localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'((64'sd1 <<< 47) - 64'sd1);
    localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(64'sd1 <<< 47);

    typedef enum logic [1:0] {
        REG_INV_VT      = 2'd0,
        REG_LOG_IS      = 2'd1,
        REG_INV_ALPHA_F = 2'd2,
        REG_INV_ALPHA_R = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [OUT_W-1:0] val;
        logic             ov;
    } clamp_t;

    // 2^(k/16) in Q30
    function automatic logic [30:0] pow2_frac(input logic [3:0] idx);
        logic [30:0] v;
        unique case (idx)
            4'd0:  v = 31'd1073741824;
            4'd1:  v = 31'd1121280436;
            4'd2:  v = 31'd1170923762;
            4'd3:  v = 31'd1222764986;
            4'd4:  v = 31'd1276901417;
            4'd5:  v = 31'd1333434672;
            4'd6:  v = 31'd1392470869;
            4'd7:  v = 31'd1454120821;
            4'd8:  v = 31'd1518500250;
            4'd9:  v = 31'd1585730000;
            4'd10: v = 31'd1655936265;
            4'd11: v = 31'd1729250827;
            4'd12: v = 31'd1805811301;
            4'd13: v = 31'd1885761398;
            4'd14: v = 31'd1969251188;
            default: v = 31'd2056437387;
        endcase
        return v;
    endfunction

    // saturate to the signed 48-bit result range
    function automatic clamp_t clamp_out(input logic signed [SUM_W-1:0] v);
        clamp_t c;
        if (v > OUT_MAX) begin
            c.val = OUT_MAX[OUT_W-1:0];
            c.ov  = 1'b1;
        end else if (v < OUT_MIN) begin
            c.val = OUT_MIN[OUT_W-1:0];
            c.ov  = 1'b1;
        end else begin
            c.val = v[OUT_W-1:0];
            c.ov  = 1'b0;
        end
        return c;
    endfunction

endpackage

// File: src/bjt_ebers_moll_currents_unit.sv
// An accepted start passes the scaling, exp, product and clamp stages to done.
// Throughput: one transaction per cycle; busy stays low, start may be held high.
// Rate is set by the fully pipelined exp units (8 stages) and multiplier stages.
// rst_n clears the valid pipeline and restores register defaults asynchronously.
// The receiver cannot stall: each result shows for one cycle with done.
module bjt_ebers_moll_currents_unit (
    input  logic                clk,
    input  logic                rst_n,
    // command side
    input  logic                start,
    output logic                busy,
    input  logic signed [23:0]  base_collector_voltage,
    input  logic signed [23:0]  base_emitter_voltage,
    // results
    output logic                done,
    output logic signed [47:0]  current_bc,
    output logic signed [47:0]  current_be,
    output logic signed [47:0]  jac_bc_bc,
    output logic signed [47:0]  jac_bc_be,
    output logic signed [47:0]  jac_be_bc,
    output logic signed [47:0]  jac_be_be,
    output logic                overflow,
    // configuration write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [24:0]         cfg_data
);

    localparam int LAT = 15;
    localparam int EW  = bjtem_pkg::E_W;
    localparam int SW  = bjtem_pkg::SUM_W;

    // ---------------------------------------------------------------
    // configuration registers: user writes only while pipe is empty; not enforced
    // ---------------------------------------------------------------
    logic [23:0]        inv_vt_reg;
    logic signed [24:0] log_is_reg;
    logic [23:0]        inv_af_reg;
    logic [23:0]        inv_ar_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_vt_reg <= 24'd2535262;
            log_is_reg <= -25'sd2112627;
            inv_af_reg <= 24'd66198;
            inv_ar_reg <= 24'd131072;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (bjtem_pkg::cfg_reg_t'(cfg_index))
                bjtem_pkg::REG_INV_VT:      inv_vt_reg <= cfg_data[23:0];
                bjtem_pkg::REG_LOG_IS:      log_is_reg <= $signed(cfg_data);
                bjtem_pkg::REG_INV_ALPHA_F: inv_af_reg <= cfg_data[23:0];
                bjtem_pkg::REG_INV_ALPHA_R: inv_ar_reg <= cfg_data[23:0];
            endcase
        end
    end

    // ---------------------------------------------------------------
    // valid pipeline: bit k marks stage k+1 holding a live transaction
    // ---------------------------------------------------------------
    logic             accept;
    logic [LAT-1:0]   vld_reg, vld_next;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign vld_next = {vld_reg[LAT-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign done = vld_reg[LAT-1];

    // stage 1: v * 1/Vt
    logic signed [48:0] p_bc_reg, p_be_reg;
    // stage 2: exponent in Q.16 with ln(Is) folded in
    logic signed [bjtem_pkg::X_W-1:0] x_bc_reg, x_be_reg, x_is;

    always_ff @(posedge clk)
    begin
        p_bc_reg <= base_collector_voltage * $signed({1'b0, inv_vt_reg});
        p_be_reg <= base_emitter_voltage * $signed({1'b0, inv_vt_reg});
        x_bc_reg <= bjtem_pkg::X_W'(p_bc_reg >>> 20) + bjtem_pkg::X_W'(log_is_reg);
        x_be_reg <= bjtem_pkg::X_W'(p_be_reg >>> 20) + bjtem_pkg::X_W'(log_is_reg);
    end

    // Is itself: user holds config static with transactions in flight; unenforced
    assign x_is = bjtem_pkg::X_W'(log_is_reg);

    // stages 3..10: exponentials
    logic [EW-1:0] ebc, ebe, isat;
    logic          ov_ebc, ov_ebe, ov_is;

    bjtem_exp u_exp_bc (.clk(clk), .x(x_bc_reg), .e(ebc),  .ov(ov_ebc));
    bjtem_exp u_exp_be (.clk(clk), .x(x_be_reg), .e(ebe),  .ov(ov_ebe));
    bjtem_exp u_exp_is (.clk(clk), .x(x_is),     .e(isat), .ov(ov_is));

    // stages 11..12: first product layer
    logic [EW-1:0] ebc_ar, is_ar, ebe_af, is_af, gbc, gbe;
    logic          ov_m0, ov_m1, ov_m2, ov_m3, ov_m4, ov_m5;

    bjtem_mulq16 u_mul_ebc_ar (.clk(clk), .e(ebc),  .c(inv_ar_reg), .r(ebc_ar), .ov(ov_m0));
    bjtem_mulq16 u_mul_is_ar  (.clk(clk), .e(isat), .c(inv_ar_reg), .r(is_ar),  .ov(ov_m1));
    bjtem_mulq16 u_mul_ebe_af (.clk(clk), .e(ebe),  .c(inv_af_reg), .r(ebe_af), .ov(ov_m2));
    bjtem_mulq16 u_mul_is_af  (.clk(clk), .e(isat), .c(inv_af_reg), .r(is_af),  .ov(ov_m3));
    bjtem_mulq16 u_mul_gbc    (.clk(clk), .e(ebc),  .c(inv_vt_reg), .r(gbc),    .ov(ov_m4));
    bjtem_mulq16 u_mul_gbe    (.clk(clk), .e(ebe),  .c(inv_vt_reg), .r(gbe),    .ov(ov_m5));

    // exp terms delayed to line up with the products
    logic [EW-1:0] ebc_d_reg [2], ebe_d_reg [2], is_d_reg [2];
    logic          ov_exp_d_reg [2];

    always_ff @(posedge clk)
    begin
        ebc_d_reg[0]    <= ebc;
        ebe_d_reg[0]    <= ebe;
        is_d_reg[0]     <= isat;
        ov_exp_d_reg[0] <= ov_ebc | ov_ebe | ov_is;
        ebc_d_reg[1]    <= ebc_d_reg[0];
        ebe_d_reg[1]    <= ebe_d_reg[0];
        is_d_reg[1]     <= is_d_reg[0];
        ov_exp_d_reg[1] <= ov_exp_d_reg[0];
    end

    // stages 13..14: Jacobian diagonal layer
    logic [EW-1:0] j00, j11;
    logic          ov_j0, ov_j1;

    bjtem_mulq16 u_mul_j00 (.clk(clk), .e(gbc), .c(inv_ar_reg), .r(j00), .ov(ov_j0));
    bjtem_mulq16 u_mul_j11 (.clk(clk), .e(gbe), .c(inv_af_reg), .r(j11), .ov(ov_j1));

    // stage 13: current sums; stage 14: aligned with j00/j11
    logic signed [SW-1:0] i0_next, i1_next;
    logic signed [SW-1:0] i0_reg [2], i1_reg [2];
    logic [EW-1:0]        gbc_d_reg [2], gbe_d_reg [2];
    logic                 ov13_reg, ov14_reg;

    assign i0_next = $signed(SW'(ebc_ar)) - $signed(SW'(is_ar))
                   + $signed(SW'(is_d_reg[1])) - $signed(SW'(ebe_d_reg[1]));
    assign i1_next = $signed(SW'(ebe_af)) - $signed(SW'(is_af))
                   - $signed(SW'(ebc_d_reg[1])) + $signed(SW'(is_d_reg[1]));

    always_ff @(posedge clk)
    begin
        i0_reg[0]    <= i0_next;
        i1_reg[0]    <= i1_next;
        i0_reg[1]    <= i0_reg[0];
        i1_reg[1]    <= i1_reg[0];
        gbc_d_reg[0] <= gbc;
        gbe_d_reg[0] <= gbe;
        gbc_d_reg[1] <= gbc_d_reg[0];
        gbe_d_reg[1] <= gbe_d_reg[0];
        ov13_reg     <= ov_exp_d_reg[1] | ov_m0 | ov_m1 | ov_m2 | ov_m3 | ov_m4 | ov_m5;
        ov14_reg     <= ov13_reg;
    end

    // stage 15: saturate to the output range and register
    bjtem_pkg::clamp_t c0, c1, c2, c3, c4, c5;
    logic signed [47:0] cur_bc_reg, cur_be_reg, j00_reg, j01_reg, j10_reg, j11_reg;
    logic               ovf_reg;

    assign c0 = bjtem_pkg::clamp_out(i0_reg[1]);
    assign c1 = bjtem_pkg::clamp_out(i1_reg[1]);
    assign c2 = bjtem_pkg::clamp_out($signed(SW'(j00)));
    assign c3 = bjtem_pkg::clamp_out(-$signed(SW'(gbe_d_reg[1])));
    assign c4 = bjtem_pkg::clamp_out(-$signed(SW'(gbc_d_reg[1])));
    assign c5 = bjtem_pkg::clamp_out($signed(SW'(j11)));

    always_ff @(posedge clk)
    begin
        cur_bc_reg <= c0.val;
        cur_be_reg <= c1.val;
        j00_reg    <= c2.val;
        j01_reg    <= c3.val;
        j10_reg    <= c4.val;
        j11_reg    <= c5.val;
        ovf_reg    <= ov14_reg | ov_j0 | ov_j1
                    | c0.ov | c1.ov | c2.ov | c3.ov | c4.ov | c5.ov;
    end

    assign current_bc = cur_bc_reg;
    assign current_be = cur_be_reg;
    assign jac_bc_bc  = j00_reg;
    assign jac_bc_be  = j01_reg;
    assign jac_be_bc  = j10_reg;
    assign jac_be_be  = j11_reg;
    assign overflow   = ovf_reg;

`ifndef SYNTHESIS
    // every accepted transaction comes out a fixed latency later
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##15 done)
        else $error("result strobe missing after accepted transaction");

    // no strobe without a transaction one stage short of the output in the cycle before
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(vld_reg[LAT-2]))
        else $error("result strobe without a transaction in flight");

    // diagonal conductances are never negative, off-diagonal never positive
    a_jac_sign: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !jac_bc_bc[47] && !jac_be_be[47]
                 && (jac_bc_be[47] || jac_bc_be == 48'd0)
                 && (jac_be_bc[47] || jac_be_bc == 48'd0))
        else $error("Jacobian sign pattern violated");
`endif

endmodule

// File: src/bjtem_exp.sv
// Pipelined exp(x): Q.16 argument in, Q.32 magnitude out, 8 register stages.
module bjtem_exp (
    input  logic                              clk,
    input  logic signed [bjtem_pkg::X_W-1:0]  x,
    output logic        [bjtem_pkg::E_W-1:0]  e,
    output logic                              ov
);

    // stage 1: scale to base 2
    logic signed [61:0] t_reg, t_next;
    // stage 2: split integer/fraction, reduce remainder to natural units
    logic [3:0]  idx_reg [2:6];
    logic signed [15:0] n_reg [2:7];
    logic [55:0] up_reg, up_next;
    // stage 3..7: Horner
    logic [25:0] u_reg [3:6];
    logic [56:0] p1_reg, p1_next;
    logic [54:0] m3_reg, m3_next;
    logic [56:0] p2_reg, p2_next;
    logic [56:0] p3_reg, p3_next;
    logic [61:0] mt_reg, mt_next;
    logic [30:0] a0, a1, a2, a3;
    logic [26:0] y1;
    // stage 8: shift into Q.32
    logic [31:0] mm;
    logic signed [16:0] sh, nsh;
    logic [bjtem_pkg::E_W-1:0] e_reg, e_next;
    logic ov_reg, ov_next;

    assign t_next  = x * $signed({1'b0, bjtem_pkg::LOG2E_Q30});
    assign up_next = t_reg[41:16] * bjtem_pkg::LN2_Q30;

    assign a0      = bjtem_pkg::ONE_Q30 + 31'(up_reg[55:30] >> 2);
    assign p1_next = up_reg[55:30] * a0;

    assign y1      = p1_reg[56:30];
    assign m3_next = y1 * bjtem_pkg::RECIP3_Q29;

    assign a1      = bjtem_pkg::ONE_Q30 + 31'(m3_reg[54:29]);
    assign p2_next = u_reg[4] * a1;

    assign a2      = bjtem_pkg::ONE_Q30 + 31'(p2_reg[56:31]);
    assign p3_next = u_reg[5] * a2;

    assign a3      = bjtem_pkg::ONE_Q30 + 31'(p3_reg[56:30]);
    assign mt_next = bjtem_pkg::pow2_frac(idx_reg[6]) * a3;

    always_comb
    begin
        mm      = mt_reg[61:30];
        sh      = 17'(n_reg[7]) + 17'sd2;
        nsh     = -sh;
        ov_next = 1'b0;
        if (sh >= 17'sd26) begin
            e_next  = bjtem_pkg::CAP_VAL;
            ov_next = 1'b1;
        end else if (sh >= 17'sd0) begin
            e_next = bjtem_pkg::E_W'(mm) << sh[4:0];
        end else if (nsh >= 17'sd32) begin
            e_next = '0;
        end else begin
            e_next = bjtem_pkg::E_W'(mm >> nsh[4:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        idx_reg[2] <= t_reg[45:42];
        n_reg[2]   <= t_reg[61:46];
        up_reg     <= up_next;
        u_reg[3]   <= up_reg[55:30];
        p1_reg     <= p1_next;
        m3_reg     <= m3_next;
        p2_reg     <= p2_next;
        p3_reg     <= p3_next;
        mt_reg     <= mt_next;
        for (int k = 3; k <= 6; k++) begin
            idx_reg[k] <= idx_reg[k-1];
        end
        for (int k = 3; k <= 7; k++) begin
            n_reg[k] <= n_reg[k-1];
        end
        for (int k = 4; k <= 6; k++) begin
            u_reg[k] <= u_reg[k-1];
        end
        e_reg  <= e_next;
        ov_reg <= ov_next;
    end

    assign e  = e_reg;
    assign ov = ov_reg;

endmodule

// File: src/bjtem_mulq16.sv
// Two-stage floor(e*c/2^16) with clamp at 2^56.
module bjtem_mulq16 (
    input  logic                                clk,
    input  logic [bjtem_pkg::E_W-1:0]           e,
    input  logic [bjtem_pkg::RECIP_W-1:0]       c,
    output logic [bjtem_pkg::E_W-1:0]           r,
    output logic                                ov
);

    logic [48:0] hi_reg, hi_next;
    logic [55:0] lo_reg, lo_next;
    logic [bjtem_pkg::E_W-1:0] sum;
    logic [bjtem_pkg::E_W-1:0] r_reg, r_next;
    logic ov_reg, ov_next;

    assign hi_next = e[56:32] * c;
    assign lo_next = e[31:0] * c;
    assign sum     = {1'b0, hi_reg[39:0], 16'b0} + bjtem_pkg::E_W'(lo_reg[55:16]);

    always_comb
    begin
        if (hi_reg[48:40] != 9'd0 || sum > bjtem_pkg::CAP_VAL) begin
            r_next  = bjtem_pkg::CAP_VAL;
            ov_next = 1'b1;
        end else begin
            r_next  = sum;
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        r_reg  <= r_next;
        ov_reg <= ov_next;
    end

    assign r  = r_reg;
    assign ov = ov_reg;

endmodule

// File: test/bjt_ebers_moll_currents_unit_test.sv
// Testbench for the Ebers-Moll current and Jacobian unit.
`timescale 1ns / 100ps

module bjt_ebers_moll_currents_unit_test;

    localparam int      LATENCY   = 15;
    localparam longint  CYCLE_CAP = 400000;   // far above the slowest correct run
    localparam longint  OUT_HI    = (64'sd1 <<< 47) - 1;
    localparam longint  OUT_LO    = -(64'sd1 <<< 47);
    localparam logic [63:0] EXP_CAP = 64'd1 << 56;

    // what one transaction on the result side should carry
    typedef struct {
        logic [47:0] i_bc;
        logic [47:0] i_be;
        logic [47:0] g_bc_bc;
        logic [47:0] g_bc_be;
        logic [47:0] g_be_bc;
        logic [47:0] g_be_be;
        logic        ov;
    } bjt_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic signed [23:0] base_collector_voltage;
    logic signed [23:0] base_emitter_voltage;
    logic        done;
    logic signed [47:0] current_bc;
    logic signed [47:0] current_be;
    logic signed [47:0] jac_bc_bc;
    logic signed [47:0] jac_bc_be;
    logic signed [47:0] jac_be_bc;
    logic signed [47:0] jac_be_be;
    logic        overflow;
    logic        cfg_valid;
    logic        cfg_ready;
    bjtem_pkg::cfg_reg_t cfg_index;
    logic [24:0] cfg_data;

    bjt_ebers_moll_currents_unit DUT (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .start                  (start),
        .busy                   (busy),
        .base_collector_voltage (base_collector_voltage),
        .base_emitter_voltage   (base_emitter_voltage),
        .done                   (done),
        .current_bc             (current_bc),
        .current_be             (current_be),
        .jac_bc_bc              (jac_bc_bc),
        .jac_bc_be              (jac_bc_be),
        .jac_be_bc              (jac_be_bc),
        .jac_be_be              (jac_be_be),
        .overflow               (overflow),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data)
    );

    // Shadow copy of the configuration registers, reset values first.
    logic [23:0] inv_vt    = 24'd2535262;
    logic [24:0] log_is    = 25'h1FFFFFF & 25'(-2112627);
    logic [23:0] inv_af    = 24'd66198;
    logic [23:0] inv_ar    = 24'd131072;

    bjt_result_t pending_results[$];
    int          mismatches = 0;
    longint      cycles     = 0;

    // 2^(k/16) in Q30, the mantissa seed of the exponential
    logic [63:0] frac_pow2[16] = '{
        64'd1073741824, 64'd1121280436, 64'd1170923762, 64'd1222764986,
        64'd1276901417, 64'd1333434672, 64'd1392470869, 64'd1454120821,
        64'd1518500250, 64'd1585730000, 64'd1655936265, 64'd1729250827,
        64'd1805811301, 64'd1885761398, 64'd1969251188, 64'd2056437387
    };

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // exp of a Q.16 argument, Q.32 magnitude, saturating at 2^56
    function automatic logic [63:0] exp_fixed(input longint x, inout logic ov);
        longint      t;
        longint      n;
        longint      sh;
        logic [63:0] f30;
        logic [63:0] r;
        logic [63:0] u;
        logic [63:0] a;
        logic [63:0] m;
        t   = x * 64'sd1549082005;
        n   = t >>> 46;                     // floor
        f30 = 64'(t - (n <<< 46)) >> 16;
        r   = f30 & 64'h3FFFFFF;
        u   = (r * 64'd744261118) >> 30;
        a   = (64'd1 << 30) + u / 4;
        a   = (64'd1 << 30) + ((u * a) >> 30) / 3;
        a   = (64'd1 << 30) + ((u * a) >> 30) / 2;
        a   = (64'd1 << 30) + ((u * a) >> 30);
        m   = (frac_pow2[f30[29:26]] * a) >> 30;
        sh  = n + 2;
        if (sh >= 26)
        begin
            ov = 1'b1;
            return EXP_CAP;
        end
        if (sh >= 0)
            return m << sh;
        if (-sh >= 63)
            return 64'd0;
        return m >> (-sh);
    endfunction

    // floor(e*c/2^16), saturating at 2^56
    function automatic logic [63:0] scale_q16(input logic [63:0] e, input logic [23:0] c,
                                              inout logic ov);
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] r;
        hi = (e >> 32) * 64'(c);
        lo = (e & 64'hFFFFFFFF) * 64'(c);
        if (hi >= (64'd1 << 40))
        begin
            ov = 1'b1;
            return EXP_CAP;
        end
        r = (hi << 16) + (lo >> 16);
        if (r > EXP_CAP)
        begin
            ov = 1'b1;
            return EXP_CAP;
        end
        return r;
    endfunction

    function automatic logic [47:0] sat48(input longint v, inout logic ov);
        if (v > OUT_HI)
        begin
            ov = 1'b1;
            return OUT_HI[47:0];
        end
        if (v < OUT_LO)
        begin
            ov = 1'b1;
            return OUT_LO[47:0];
        end
        return v[47:0];
    endfunction

    function automatic longint junction_exponent(input logic signed [23:0] v);
        longint p;
        p = longint'(v) * longint'({40'd0, inv_vt});
        return (p >>> 20) + longint'($signed(log_is));
    endfunction

    function automatic bjt_result_t predict_currents(input logic signed [23:0] vbc,
                                                     input logic signed [23:0] vbe);
        bjt_result_t res;
        logic        ov;
        logic [63:0] ebc;
        logic [63:0] ebe;
        logic [63:0] sat_i;
        logic [63:0] gbc;
        logic [63:0] gbe;
        logic [63:0] j00;
        logic [63:0] j11;
        longint      i0;
        longint      i1;
        ov    = 1'b0;
        ebc   = exp_fixed(junction_exponent(vbc), ov);
        ebe   = exp_fixed(junction_exponent(vbe), ov);
        sat_i = exp_fixed(longint'($signed(log_is)), ov);
        i0 = longint'(scale_q16(ebc, inv_ar, ov)) - longint'(scale_q16(sat_i, inv_ar, ov))
             + longint'(sat_i) - longint'(ebe);
        i1 = longint'(scale_q16(ebe, inv_af, ov)) - longint'(scale_q16(sat_i, inv_af, ov))
             - longint'(ebc) + longint'(sat_i);
        gbc = scale_q16(ebc, inv_vt, ov);
        gbe = scale_q16(ebe, inv_vt, ov);
        j00 = scale_q16(gbc, inv_ar, ov);
        j11 = scale_q16(gbe, inv_af, ov);
        res.i_bc    = sat48(i0, ov);
        res.i_be    = sat48(i1, ov);
        res.g_bc_bc = sat48(longint'(j00), ov);
        res.g_bc_be = sat48(-longint'(gbe), ov);
        res.g_be_bc = sat48(-longint'(gbc), ov);
        res.g_be_be = sat48(longint'(j11), ov);
        res.ov      = ov;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        mismatches++;
        $display("%0t mismatch on %s: got %h expected %h", $realtime, what, got, want);
    endtask

    // One command transaction; start stays high across back-to-back items.
    task automatic send_voltages(input logic signed [23:0] vbc, input logic signed [23:0] vbe);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0)
            gap = 0;                        // favor runs of back-to-back items
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start                  <= 1'b1;
        base_collector_voltage <= vbc;
        base_emitter_voltage   <= vbe;
        do @(posedge clk); while (busy);
        pending_results.push_back(predict_currents(vbc, vbe));
    endtask

    // Drain the pipeline so that registers change only while idle.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_reg(input bjtem_pkg::cfg_reg_t idx, input logic [24:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            bjtem_pkg::REG_INV_VT:      inv_vt = value[23:0];
            bjtem_pkg::REG_LOG_IS:      log_is = value;
            bjtem_pkg::REG_INV_ALPHA_F: inv_af = value[23:0];
            default:                    inv_ar = value[23:0];
        endcase
    endtask

    task automatic write_all(input logic [23:0] vt, input logic [24:0] lis,
                             input logic [23:0] af, input logic [23:0] ar);
        write_reg(bjtem_pkg::REG_INV_VT, {1'b0, vt});
        write_reg(bjtem_pkg::REG_LOG_IS, lis);
        write_reg(bjtem_pkg::REG_INV_ALPHA_F, {1'b0, af});
        write_reg(bjtem_pkg::REG_INV_ALPHA_R, {1'b0, ar});
    endtask

    // Mostly voltages within about one volt; the rest spans the whole field.
    function automatic logic signed [23:0] pick_voltage();
        case ($urandom_range(0, 3))
            0, 1:    return 24'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            2:       return 24'($urandom);
            default: return 24'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
        endcase
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_voltages(pick_voltage(), pick_voltage());
    endtask

    // Field extremes, zero bias, deep reverse bias (exponential below one step)
    // and strong forward bias (saturated exponential and clamped outputs).
    task automatic test_directed();
        logic signed [23:0] corner[6];
        corner = '{24'sh800000, 24'sh7FFFFF, 24'sd0, -24'sd1, 24'sd1 <<< 20, -(24'sd1 <<< 20)};
        foreach (corner[i])
            send_voltages(corner[i], corner[(i + 1) % 6]);
        send_voltages(24'sh7FFFFF, 24'sh7FFFFF);
        send_voltages(24'sh800000, 24'sh800000);
        send_voltages(24'sd700000, 24'sd0);
        send_voltages(24'sd0, 24'sd700000);
        wait_idle();
    endtask

    task automatic test_reset_values();
        send_random(300);
        wait_idle();
    endtask

    // All registers at their extremes, both low and high, then a mixed setting.
    task automatic test_register_extremes();
        write_all(24'd0, 25'h1000000, 24'd0, 24'd0);
        test_directed();
        send_random(80);
        wait_idle();
        write_all(24'hFFFFFF, 25'h0FFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        test_directed();
        send_random(80);
        wait_idle();
        write_all(24'hFFFFFF, 25'h1000000, 24'd65536, 24'd0);
        send_random(80);
        wait_idle();
    endtask

    // Random settings: thermal voltage 1/128 V to 1/16 V, saturation current
    // across many decades, 1/alpha_f 1 to 3.05, 1/alpha_r 1 to 16, then random.
    task automatic test_random_registers();
        repeat (6)
        begin
            write_all(24'($urandom_range(1 << 20, 1 << 23)),
                      25'($signed($urandom_range(0, 3 << 20)) - (3 << 20)),
                      24'($urandom_range(65536, 200000)),
                      24'($urandom_range(65536, 1 << 20)));
            send_random(110);
            wait_idle();
        end
        write_all(24'($urandom), 25'($urandom), 24'($urandom), 24'($urandom));
        send_random(80);
        wait_idle();
    endtask

    // Every result is checked against the oldest prediction.
    always @(posedge clk)
    begin
        bjt_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result strobe with no pending transaction", 48'd1, 48'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (current_bc !== want.i_bc)
                    report_mismatch("current_bc", current_bc, want.i_bc);
                if (current_be !== want.i_be)
                    report_mismatch("current_be", current_be, want.i_be);
                if (jac_bc_bc !== want.g_bc_bc)
                    report_mismatch("jac_bc_bc", jac_bc_bc, want.g_bc_bc);
                if (jac_bc_be !== want.g_bc_be)
                    report_mismatch("jac_bc_be", jac_bc_be, want.g_bc_be);
                if (jac_be_bc !== want.g_be_bc)
                    report_mismatch("jac_be_bc", jac_be_bc, want.g_be_bc);
                if (jac_be_be !== want.g_be_be)
                    report_mismatch("jac_be_be", jac_be_be, want.g_be_be);
                if (overflow !== want.ov)
                    report_mismatch("overflow", {47'd0, overflow}, {47'd0, want.ov});
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("bjt_ebers_moll_currents_unit_test: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n                  = 1'b0;
        start                  = 1'b0;
        base_collector_voltage = '0;
        base_emitter_voltage   = '0;
        cfg_valid              = 1'b0;
        cfg_index              = bjtem_pkg::REG_INV_VT;
        cfg_data               = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_reset_values();
        test_register_extremes();
        test_random_registers();
        // back to the reset values, written explicitly
        write_all(24'd2535262, 25'h1FFFFFF & 25'(-2112627), 24'd66198, 24'd131072);
        send_random(120);
        wait_idle();

        if (pending_results.size() != 0)
            report_mismatch("results never returned", 48'(pending_results.size()), 48'd0);
        if (mismatches == 0)
            $display("bjt_ebers_moll_currents_unit_test: PASS");
        else
            $display("bjt_ebers_moll_currents_unit_test: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
src/bjtem_pkg.sv
src/bjtem_exp.sv
src/bjtem_mulq16.sv
src/bjt_ebers_moll_currents_unit.sv
test/bjt_ebers_moll_currents_unit_test.sv
